// ===== rtl/core/aes128_pkg.sv =====
// package: types, s-box and round helpers for the aes-128 encrypt pipeline
`timescale 1ns / 1ps
`default_nettype none
package aes128_pkg;

   localparam int NUM_ROUNDS = 10;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_word_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_word_type;

   // data handed from one round cell to the next
   typedef struct packed {
      logic         valid;
      logic [127:0] state;
      logic [127:0] round_key;
   } cell_link_type;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      unique case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] rnd);
      logic [7:0] r;
      unique case (rnd)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits 127-8i
   function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/aes128_block_encrypt.sv =====
// top level: key registers, whitening stage and the chain of ten round cells
`timescale 1ns / 1ps
`default_nettype none
// AES-128 block encryption. One 128-bit word is accepted per cycle and its
// ciphertext is formed in one whitening stage and ten round cells, each cell
// doing one round and its own key expansion step. The whole chain moves
// together and halts while the output word at its end is not taken, so
// throughput is one word per cycle with a ready downstream. The key must be
// written through the csr port while no word is in flight; the block does not enforce it.
module aes128_block_encrypt
   import aes128_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   logic [63:0]   key_high_ff, key_low_ff;
   logic          advance;
   cell_link_type link [0:NUM_ROUNDS];
   logic          valid0_ff;
   logic [127:0]  state0_ff;
   logic [127:0]  key0_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // chain moves when its tail is empty or being taken
   assign advance   = !link[NUM_ROUNDS].valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state0_ff <= {req_data.plain_high, req_data.plain_low} ^ {key_high_ff, key_low_ff};
         key0_ff   <= {key_high_ff, key_low_ff};
      end
   end

   assign link[0] = '{valid: valid0_ff, state: state0_ff, round_key: key0_ff};

   for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_cell
      aes128_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_num (4'(g)),
         .link_in   (link[g-1]),
         .link_out  (link[g])
      );
   end

   assign rsp_valid = link[NUM_ROUNDS].valid;
   assign rsp_data  = '{cipher_high: link[NUM_ROUNDS].state[127:64],
                        cipher_low:  link[NUM_ROUNDS].state[63:0]};

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty tail");
   a_word_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> link[0].valid)
      else $error("accepted word lost at entry");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/aes128_round_cell.sv =====
// one round cell: a round of the cipher plus the matching key expansion step
`timescale 1ns / 1ps
`default_nettype none
module aes128_round_cell
   import aes128_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic [3:0]    round_num,
   input  wire cell_link_type link_in,
   output cell_link_type      link_out
);
   logic [127:0] key_in;
   logic [127:0] shifted;
   logic [127:0] mixed;
   logic [31:0]  tmp_word;
   logic         valid_ff;
   logic [127:0] state_ff;
   logic [127:0] key_ff;

   // next round key from the previous one
   always_comb begin
      logic [31:0] w0, w1, w2, w3, last;
      last = link_in.round_key[31:0];
      tmp_word = {sbox(last[23:16]), sbox(last[15:8]), sbox(last[7:0]), sbox(last[31:24])}
                 ^ {rcon(round_num), 24'h0};
      w0 = link_in.round_key[127:96] ^ tmp_word;
      w1 = link_in.round_key[95:64] ^ w0;
      w2 = link_in.round_key[63:32] ^ w1;
      w3 = link_in.round_key[31:0] ^ w2;
      key_in = {w0, w1, w2, w3};
   end

   // sub bytes with shift rows folded into the byte select
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shifted[127 - 8*(4*c + r) -: 8] =
               sbox(byte_at(link_in.state, 4*((c + r) % 4) + r));
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
         a0 = byte_at(shifted, 4*c);     a1 = byte_at(shifted, 4*c + 1);
         a2 = byte_at(shifted, 4*c + 2); a3 = byte_at(shifted, 4*c + 3);
         d0 = gf_dbl(a0); d1 = gf_dbl(a1); d2 = gf_dbl(a2); d3 = gf_dbl(a3);
         mixed[127 - 32*c -: 32] = {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
                                    a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= link_in.valid;
      end
   end

   // last round leaves out the column mix
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= ((round_num == 4'(NUM_ROUNDS)) ? shifted : mixed) ^ key_in;
         key_ff   <= key_in;
      end
   end

   assign link_out = '{valid: valid_ff, state: state_ff, round_key: key_ff};
endmodule
`default_nettype wire

// ===== tb/sv/tb_aes128_block_encrypt.sv =====
// testbench for the aes-128 encrypt pipeline: random and directed blocks under several keys
`timescale 1ns / 1ps
`default_nettype none
module tb_aes128_block_encrypt;
   import aes128_pkg::*;

   // expected ciphertext words in order of acceptance
   class cipher_scoreboard;
      rsp_word_type pending[$];
      int mismatches = 0;
      int unexpected = 0;
      int checked = 0;

      function void note_block(rsp_word_type expected_word);
         pending.push_back(expected_word);
      endfunction

      function void check_block(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected ciphertext %h_%h", got.cipher_high, got.cipher_low);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.cipher_high !== got.cipher_high || want.cipher_low !== got.cipher_low) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
               $display("mismatch: expected %h_%h got %h_%h", want.cipher_high,
                        want.cipher_low, got.cipher_high, got.cipher_low);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_KEY_HIGH;
   logic [63:0] csr_data = '0;

   aes128_block_encrypt dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   cipher_scoreboard board = new();
   logic [63:0] key_hi_shadow = '0;
   logic [63:0] key_lo_shadow = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int blocks_sent = 0;
   int keys_used = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   localparam logic [7:0] SBOX_TAB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };
   localparam logic [7:0] ROUND_CONST [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // state bytes: byte i at bits 127-8i, column c holds bytes 4c..4c+3
   function automatic rsp_word_type encrypt_block(input logic [127:0] key,
                                                  input logic [127:0] plain);
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] out;
      rsp_word_type res;
      for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {SBOX_TAB[t[31:24]], SBOX_TAB[t[23:16]], SBOX_TAB[t[15:8]], SBOX_TAB[t[7:0]]};
            t[31:24] ^= ROUND_CONST[i/4 - 1];
         end
         w[i] = w[i-4] ^ t;
      end
      for (int i = 0; i < 16; i++) st[i] = plain[127 - 8*i -: 8] ^ w[i/4][31 - 8*(i%4) -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) tmp[4*c + r] = SBOX_TAB[st[4*((c + r) % 4) + r]];
         st = tmp;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               st[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
               st[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
               st[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
               st[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= w[4*rnd + i/4][31 - 8*(i%4) -: 8];
      end
      for (int i = 0; i < 16; i++) out[127 - 8*i -: 8] = st[i];
      res.cipher_high = out[127:64];
      res.cipher_low = out[63:0];
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = 64'h1 << $urandom_range(0, 63);
         default: v = {$urandom(), $urandom()};
      endcase
      return v;
   endfunction

   // receiver side and cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_block(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_KEY_HIGH) key_hi_shadow = value;
      else key_lo_shadow = value;
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      rsp_word_type expected_word;
      req_data <= '{plain_high: hi, plain_low: lo};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_word = encrypt_block({key_hi_shadow, key_lo_shadow}, {hi, lo});
      board.note_block(expected_word);
      blocks_sent++;
      // the valid stays up into the next item when no gap is drawn
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic new_key(input logic [63:0] hi, input logic [63:0] lo);
      drain();
      write_key(CSR_KEY_HIGH, hi);
      write_key(CSR_KEY_LOW, lo);
      keys_used++;
   endtask

   initial begin
      int idle_tab [4] = '{0, 75, 0, 13};
      int stall_tab [4] = '{0, 0, 75, 13};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset key of all zeros first
      send_block('0, '0);
      send_block('1, '1);
      new_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
      new_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '1);
      new_key('1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h1);
      new_key('1, '0);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = idle_tab[ph % 4];
         recv_stall_pct = stall_tab[ph % 4];
         new_key(rand64(), rand64());
         repeat (80) send_block(rand64(), rand64());
      end
      drain();
      $display("ran %0d blocks under %0d keys with varied idle and stall rates",
               blocks_sent, keys_used + 1);
      $display("checked %0d ciphertext words, %0d mismatches, %0d unexpected",
               board.checked, board.mismatches, board.unexpected);
      if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/aes128_pkg.sv
rtl/core/aes128_round_cell.sv
rtl/core/aes128_block_encrypt.sv
tb/sv/tb_aes128_block_encrypt.sv
